// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files; sha1_hash_engine.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while reset is released.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Assertion failed.");

// Next-cycle implication, checked only while reset is released.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("Assertion failed.");

`endif

// ----- rtl/sha1_pkg.sv -----
package sha1_pkg;

	localparam int unsigned WordW      = 32;
	localparam int unsigned NumChain   = 5;
	localparam int unsigned WinDepth   = 16;
	localparam int unsigned FifoDepth  = 4;
	localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
	localparam int unsigned FifoCntW   = FifoPtrW + 1;

	localparam logic [NumChain-1:0][WordW-1:0] IV_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [WordW-1:0] K_0 = 32'h5A827999;
	localparam logic [WordW-1:0] K_1 = 32'h6ED9EBA1;
	localparam logic [WordW-1:0] K_2 = 32'h8F1BBCDC;
	localparam logic [WordW-1:0] K_3 = 32'hCA62C1D6;

	localparam logic [6:0] ROUND_SCHED = 7'd16;
	localparam logic [6:0] ROUND_P1    = 7'd20;
	localparam logic [6:0] ROUND_P2    = 7'd40;
	localparam logic [6:0] ROUND_P3    = 7'd60;
	localparam logic [6:0] ROUND_LAST  = 7'd79;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [7:0] ZERO_BYTE = 8'h00;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] BLOCK_END = 6'd63;

	localparam logic [2:0] FIRST_WORD_IDX = 3'd0;
	localparam logic [2:0] LAST_WORD_IDX  = 3'd4;

	typedef enum logic [1:0] {
		CMD_BYTE      = 2'd0,
		CMD_BYTE_LAST = 2'd1,
		CMD_LAST      = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PAD  = 5'b00010,
		ST_COMP = 5'b00100,
		ST_ADD  = 5'b01000,
		ST_EMIT = 5'b10000
	} core_state_t;

	function automatic logic [WordW-1:0] round_f(input logic [6:0] t,
			input logic [WordW-1:0] b, input logic [WordW-1:0] c,
			input logic [WordW-1:0] d);
		logic [WordW-1:0] f;
		if (t < ROUND_P1) begin
			f = (b & c) | (~b & d);
		end else if (t < ROUND_P2) begin
			f = b ^ c ^ d;
		end else if (t < ROUND_P3) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic logic [WordW-1:0] round_k(input logic [6:0] t);
		logic [WordW-1:0] k;
		if (t < ROUND_P1) begin
			k = K_0;
		end else if (t < ROUND_P2) begin
			k = K_1;
		end else if (t < ROUND_P3) begin
			k = K_2;
		end else begin
			k = K_3;
		end
		return k;
	endfunction

endpackage

// ----- rtl/sha1_front.sv -----
module sha1_front (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // data_byte
	input  logic              s_tuser,   // has_byte
	input  logic              s_tlast,   // is_last
	input  logic              fifo_full,
	output logic              push,
	output sha1_pkg::cmd_t    cmd
);

	logic beat;

	assign s_tready = !fifo_full;
	assign beat     = s_tvalid && s_tready;

	// A beat with neither a byte nor the end mark has no effect and is dropped here.
	assign push = beat && (s_tuser || s_tlast);

	always_comb begin
		cmd.data = s_tdata;
		if (s_tuser && s_tlast) begin
			cmd.kind = sha1_pkg::CMD_BYTE_LAST;
		end else if (s_tuser) begin
			cmd.kind = sha1_pkg::CMD_BYTE;
		end else begin
			cmd.kind = sha1_pkg::CMD_LAST;
		end
	end

endmodule

// ----- rtl/sha1_fifo.sv -----
module sha1_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sha1_pkg::cmd_t    wr_cmd,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output sha1_pkg::cmd_t    rd_cmd
);

	sha1_pkg::cmd_t                  mem_q [sha1_pkg::FifoDepth];
	logic [sha1_pkg::FifoPtrW-1:0]   wr_ptr_q;
	logic [sha1_pkg::FifoPtrW-1:0]   rd_ptr_q;
	logic [sha1_pkg::FifoCntW-1:0]   count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full    = (count_q == sha1_pkg::FifoCntW'(sha1_pkg::FifoDepth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/sha1_core.sv -----
module sha1_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  sha1_pkg::cmd_t    cmd,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // digest_word
	output logic [2:0]        m_tuser,   // word_index
	output logic              m_tlast    // last_word
);

	sha1_pkg::core_state_t    state_q;
	sha1_pkg::core_state_t    state_d;

	logic [31:0]  win_q   [sha1_pkg::WinDepth];
	logic [31:0]  regs_q  [sha1_pkg::NumChain];
	logic [31:0]  chain_q [sha1_pkg::NumChain];
	logic [60:0]  byte_count_q;
	logic [5:0]   pos_q;
	logic [6:0]   round_q;
	logic         fin_q;
	logic         sent80_q;
	logic         in_len_q;
	logic [63:0]  len_q;
	logic [2:0]   emit_idx_q;
	logic         out_valid_q;
	logic [31:0]  out_data_q;
	logic [2:0]   out_idx_q;

	logic         take_cmd;
	logic         wr_en;
	logic [7:0]   wr_byte;
	logic         len_sel;
	logic         block_done;
	logic         emit_load;
	logic         emit_done;
	logic [31:0]  w_sched;
	logic [31:0]  w_t;
	logic [31:0]  tmp;

	assign take_cmd  = (state_q == sha1_pkg::ST_IDLE) && cmd_valid;
	assign pop       = take_cmd;
	assign len_sel   = (state_q == sha1_pkg::ST_PAD) && sent80_q
		&& (in_len_q || (pos_q == sha1_pkg::LEN_POS));
	assign emit_load = (state_q == sha1_pkg::ST_EMIT) && (!out_valid_q || m_tready);
	assign emit_done = emit_load && (emit_idx_q == sha1_pkg::LAST_WORD_IDX);

	always_comb begin
		wr_en   = 1'b0;
		wr_byte = cmd.data;
		if (take_cmd) begin
			wr_en = (cmd.kind != sha1_pkg::CMD_LAST);
		end else if (state_q == sha1_pkg::ST_PAD) begin
			wr_en = 1'b1;
			if (!sent80_q) begin
				wr_byte = sha1_pkg::PAD_BYTE;
			end else if (len_sel) begin
				wr_byte = len_q[63:56];
			end else begin
				wr_byte = sha1_pkg::ZERO_BYTE;
			end
		end
	end

	assign block_done = wr_en && (pos_q == sha1_pkg::BLOCK_END);

	always_comb begin
		logic [31:0] x;
		x       = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		w_sched = {x[30:0], x[31]};
		w_t     = (round_q < sha1_pkg::ROUND_SCHED) ? win_q[0] : w_sched;
		tmp     = {regs_q[0][26:0], regs_q[0][31:27]}
			+ sha1_pkg::round_f(round_q, regs_q[1], regs_q[2], regs_q[3])
			+ regs_q[4] + w_t + sha1_pkg::round_k(round_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha1_pkg::ST_IDLE: begin
				if (take_cmd) begin
					if (block_done) begin
						state_d = sha1_pkg::ST_COMP;
					end else if (cmd.kind != sha1_pkg::CMD_BYTE) begin
						state_d = sha1_pkg::ST_PAD;
					end
				end
			end
			sha1_pkg::ST_PAD: begin
				if (block_done) begin
					state_d = sha1_pkg::ST_COMP;
				end
			end
			sha1_pkg::ST_COMP: begin
				if (round_q == sha1_pkg::ROUND_LAST) begin
					state_d = sha1_pkg::ST_ADD;
				end
			end
			sha1_pkg::ST_ADD: begin
				if (!fin_q) begin
					state_d = sha1_pkg::ST_IDLE;
				end else if (in_len_q) begin
					state_d = sha1_pkg::ST_EMIT;
				end else begin
					state_d = sha1_pkg::ST_PAD;
				end
			end
			sha1_pkg::ST_EMIT: begin
				if (emit_done) begin
					state_d = sha1_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha1_pkg::ST_IDLE;
			end
		endcase
	end

	// Block buffer: bytes shift in big-endian; during rounds it rolls the schedule.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < sha1_pkg::WinDepth - 1; i++) begin
				win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
			end
			win_q[sha1_pkg::WinDepth-1] <= {win_q[sha1_pkg::WinDepth-1][23:0], wr_byte};
		end else if (state_q == sha1_pkg::ST_COMP) begin
			for (int i = 0; i < sha1_pkg::WinDepth - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[sha1_pkg::WinDepth-1] <= w_t;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_data_q <= chain_q[emit_idx_q];
			out_idx_q  <= emit_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sha1_pkg::ST_IDLE;
			byte_count_q <= '0;
			pos_q        <= '0;
			round_q      <= '0;
			fin_q        <= 1'b0;
			sent80_q     <= 1'b0;
			in_len_q     <= 1'b0;
			len_q        <= '0;
			emit_idx_q   <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < sha1_pkg::NumChain; i++) begin
				chain_q[i] <= sha1_pkg::IV_INIT[i];
				regs_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;

			if (wr_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (take_cmd && wr_en) begin
				byte_count_q <= byte_count_q + 61'd1;
			end
			if (take_cmd && (cmd.kind != sha1_pkg::CMD_BYTE)) begin
				fin_q <= 1'b1;
			end

			if ((state_q == sha1_pkg::ST_PAD) && !sent80_q) begin
				sent80_q <= 1'b1;
				len_q    <= {byte_count_q, 3'b000};
			end else if (len_sel) begin
				in_len_q <= 1'b1;
				len_q    <= {len_q[55:0], 8'h00};
			end

			if (block_done) begin
				round_q <= '0;
				for (int i = 0; i < sha1_pkg::NumChain; i++) begin
					regs_q[i] <= chain_q[i];
				end
			end else if (state_q == sha1_pkg::ST_COMP) begin
				round_q   <= round_q + 7'd1;
				regs_q[0] <= tmp;
				regs_q[1] <= regs_q[0];
				regs_q[2] <= {regs_q[1][1:0], regs_q[1][31:2]};
				regs_q[3] <= regs_q[2];
				regs_q[4] <= regs_q[3];
			end

			if (state_q == sha1_pkg::ST_ADD) begin
				round_q <= '0;
				for (int i = 0; i < sha1_pkg::NumChain; i++) begin
					chain_q[i] <= chain_q[i] + regs_q[i];
				end
			end

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_done) begin
				emit_idx_q   <= sha1_pkg::FIRST_WORD_IDX;
				byte_count_q <= '0;
				pos_q        <= '0;
				fin_q        <= 1'b0;
				sent80_q     <= 1'b0;
				in_len_q     <= 1'b0;
				for (int i = 0; i < sha1_pkg::NumChain; i++) begin
					chain_q[i] <= sha1_pkg::IV_INIT[i];
				end
			end else if (emit_load) begin
				emit_idx_q <= emit_idx_q + 3'd1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_idx_q;
	assign m_tlast  = (out_idx_q == sha1_pkg::LAST_WORD_IDX);

endmodule

// ----- rtl/sha1_hash_engine.sv -----
// SHA-1 hash engine. Message bytes enter one beat at a time on the slave stream; a beat with
// tlast high ends the message, with or without a byte (tuser low). The engine pads the message,
// finishes it and sends the 160-bit digest as five beats, H0 first, with tlast on the fifth,
// then starts the next message from the initial vector. A four-entry queue takes input beats at
// one per cycle while it is not full, also while the hashing core works. The core takes message
// bytes only while idle; each 64-byte block, padding included, runs 80 rounds on one shared
// round unit plus the chaining add. The digest beats wait while the output is stalled, and on a
// long message the round unit bounds the rate.
`include "assert_macros.svh"

module sha1_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // has_byte
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // digest_word
	output logic [2:0]  m_tuser,   // word_index
	output logic        m_tlast    // last_word
);

	sha1_pkg::cmd_t cmd_in;
	sha1_pkg::cmd_t cmd_out;
	logic           push;
	logic           pop;
	logic           fifo_full;
	logic           fifo_empty;

	sha1_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.fifo_full (fifo_full),
		.push      (push),
		.cmd       (cmd_in)
	);

	sha1_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd_in),
		.pop    (pop),
		.full   (fifo_full),
		.empty  (fifo_empty),
		.rd_cmd (cmd_out)
	);

	sha1_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!fifo_empty),
		.cmd       (cmd_out),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	`ASSERT_IMPLIES(a_no_push_when_full, clk, arst_n, push, !fifo_full)
	`ASSERT_IMPLIES(a_empty_beat_dropped, clk, arst_n, s_tvalid && s_tready && !s_tuser && !s_tlast, !push)
	`ASSERT_IMPLIES(a_last_on_final_word, clk, arst_n, m_tvalid, m_tlast == (m_tuser == sha1_pkg::LAST_WORD_IDX))
	`ASSERT_NEXT(a_index_restarts, clk, arst_n, m_tvalid && m_tready && m_tlast, !m_tvalid || (m_tuser == sha1_pkg::FIRST_WORD_IDX))

endmodule

// ----- bench/sha1_hash_engine_tb.sv -----
module sha1_hash_engine_tb;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned HOLD_AFTER  = 40;
	localparam int unsigned DRAIN_WAIT  = 300;
	localparam int unsigned RANDOM_BEATS = 200;
	localparam int unsigned QUIET_FROM   = 165;

	localparam logic [31:0] SHA1_IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam logic [31:0] RK_0 = 32'h5A827999;
	localparam logic [31:0] RK_1 = 32'h6ED9EBA1;
	localparam logic [31:0] RK_2 = 32'h8F1BBCDC;
	localparam logic [31:0] RK_3 = 32'hCA62C1D6;
	localparam logic [7:0]  PAD_MARK = 8'h80;
	localparam logic [5:0]  LEN_FIELD_POS = 6'd56;
	localparam logic [5:0]  BLOCK_TAIL = 6'd63;

	typedef struct {
		logic [7:0] data;
		logic       has_byte;
		logic       is_last;
		logic       quiet;
	} msg_beat_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // data_byte
	logic        s_tuser = 1'b0;  // has_byte
	logic        s_tlast = 1'b0;  // is_last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // digest_word
	logic [2:0]  m_tuser;         // word_index
	logic        m_tlast;         // last_word

	msg_beat_t    msg_beats [$];
	digest_beat_t digest_q [$];
	msg_beat_t    next_beat;
	digest_beat_t seen_beat;

	logic [31:0] chain [5];
	logic [7:0]  block_buf [64];
	logic [60:0] msg_bytes;

	int unsigned in_gap = 0;
	int unsigned out_gap = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	logic        quiet_phase = 1'b0;
	int unsigned digest_beats_seen = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned random_beats;
	int unsigned msg_len;

	sha1_hash_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void compress_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) begin
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		end
		for (int i = 16; i < 80; i++) begin
			w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		end
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = RK_0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = RK_1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = RK_2;
			end else begin
				f = b ^ c ^ d;
				k = RK_3;
			end
			t = rotl32(a, 5) + f + e + w[i] + k;
			e = d;
			d = c;
			c = rotl32(b, 30);
			b = a;
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
	endfunction

	function automatic void put_block_byte(input logic [5:0] pos, input logic [7:0] value);
		block_buf[pos] = value;
		if (pos == BLOCK_TAIL) begin
			compress_block();
		end
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < 5; i++) begin
			chain[i] = SHA1_IV[i];
		end
		msg_bytes = '0;
	endfunction

	// Absorbs one accepted beat; on the last beat pads the message and queues the digest.
	function automatic void absorb_beat(input logic [7:0] data, input logic has_byte,
			input logic is_last);
		logic [5:0]   pos;
		logic [63:0]  bit_len;
		digest_beat_t dw;
		if (has_byte) begin
			put_block_byte(msg_bytes[5:0], data);
			msg_bytes = msg_bytes + 61'd1;
		end
		if (is_last) begin
			bit_len = {msg_bytes, 3'b000};
			pos = msg_bytes[5:0];
			put_block_byte(pos, PAD_MARK);
			pos = pos + 6'd1;
			while (pos != LEN_FIELD_POS) begin
				put_block_byte(pos, 8'h00);
				pos = pos + 6'd1;
			end
			for (int i = 0; i < 8; i++) begin
				put_block_byte(pos, bit_len[63 - 8*i -: 8]);
				pos = pos + 6'd1;
			end
			for (int i = 0; i < 5; i++) begin
				dw.word = chain[i];
				dw.index = 3'(i);
				dw.last = (i == 4);
				digest_q.push_back(dw);
			end
			restart_hash();
		end
	endfunction

	function automatic void add_beat(input logic [7:0] data, input logic has_byte,
			input logic is_last, input logic quiet);
		msg_beat_t mb;
		mb.data = data;
		mb.has_byte = has_byte;
		mb.is_last = is_last;
		mb.quiet = quiet;
		msg_beats.push_back(mb);
	endfunction

	// Queues a message of random content and returns the number of beats that matter.
	function automatic int unsigned add_message(input int unsigned len, input logic quiet);
		int unsigned count;
		logic        byte_on_last;
		count = 0;
		byte_on_last = 1'($urandom_range(0, 1));
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				add_beat(8'($urandom), 1'b0, 1'b0, quiet);
			end
			add_beat(8'($urandom), 1'b1, (i == len - 1) && byte_on_last, quiet);
			count++;
		end
		if (len == 0 || !byte_on_last) begin
			add_beat(8'($urandom), 1'b0, 1'b1, quiet);
			count++;
		end
		return count;
	endfunction

	function automatic void match(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %h, got %h", name, want, got);
			errors++;
		end
	endfunction

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			in_gap <= 0;
			quiet_phase <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				absorb_beat(s_tdata, s_tuser, s_tlast);
			end
			if (!s_tvalid || s_tready) begin
				if (in_gap != 0) begin
					s_tvalid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (msg_beats.size() != 0) begin
					next_beat = msg_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_beat.data;
					s_tuser <= next_beat.has_byte;
					s_tlast <= next_beat.is_last;
					quiet_phase <= next_beat.quiet;
					if (!next_beat.quiet && $urandom_range(0, 5) == 0) begin
						in_gap <= $urandom_range(1, 15);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_gap <= 0;
			digest_beats_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				digest_beats_seen <= digest_beats_seen + 1;
				if (digest_q.size() == 0) begin
					$error("Digest beat with nothing expected: word %h index %0d last %b",
						m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					seen_beat = digest_q.pop_front();
					match("digest_word", seen_beat.word, m_tdata);
					match("word_index", 32'(seen_beat.index), 32'(m_tuser));
					match("last_word", 32'(seen_beat.last), 32'(m_tlast));
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (out_gap != 0) begin
				m_tready <= 1'b0;
				out_gap <= out_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if (!quiet_phase && $urandom_range(0, 7) == 0) begin
					out_gap <= $urandom_range(1, 15);
				end
			end
		end
	end

	// One long output stall, started once enough digest beats have gone through.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && digest_beats_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	initial begin
		restart_hash();
		for (int i = 0; i < 64; i++) begin
			block_buf[i] = 8'h00;
		end

		// Empty message, then a beat with neither flag before two one-byte messages and "abc".
		add_beat(8'h00, 1'b0, 1'b1, 1'b0);
		add_beat(8'hA5, 1'b0, 1'b0, 1'b0);
		add_beat(8'h00, 1'b1, 1'b1, 1'b0);
		add_beat(8'hFF, 1'b1, 1'b1, 1'b0);
		add_beat(8'h61, 1'b1, 1'b0, 1'b0);
		add_beat(8'h62, 1'b1, 1'b0, 1'b0);
		add_beat(8'h63, 1'b1, 1'b1, 1'b0);
		// The same bytes ended by a marker that carries no byte.
		add_beat(8'h61, 1'b1, 1'b0, 1'b0);
		add_beat(8'hFF, 1'b0, 1'b0, 1'b0);
		add_beat(8'h62, 1'b1, 1'b0, 1'b0);
		add_beat(8'h63, 1'b1, 1'b0, 1'b0);
		add_beat(8'hFF, 1'b0, 1'b1, 1'b0);
		add_beat(8'h00, 1'b1, 1'b0, 1'b0);
		add_beat(8'hFF, 1'b1, 1'b0, 1'b0);
		add_beat(8'h55, 1'b1, 1'b0, 1'b0);
		add_beat(8'hAA, 1'b1, 1'b1, 1'b0);

		// The lengths just below and at the padding boundary come first.
		random_beats = add_message(55, 1'b0);
		random_beats += add_message(56, 1'b0);
		while (random_beats < RANDOM_BEATS) begin
			if ($urandom_range(0, 9) == 0) begin
				msg_len = $urandom_range(54, 66);
			end else begin
				msg_len = $urandom_range(0, 10);
			end
			random_beats += add_message(msg_len, random_beats >= QUIET_FROM);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (msg_beats.size() != 0 || s_tvalid || digest_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sha1_pkg.sv
rtl/sha1_front.sv
rtl/sha1_fifo.sv
rtl/sha1_core.sv
rtl/sha1_hash_engine.sv
bench/sha1_hash_engine_tb.sv
